// File: rtl/aes128_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aes128_pkg;

  localparam int unsigned NumRounds = 10;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    get_byte = s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[127-8*i -: 8] = inv ? INV_BOX[get_byte(s, i)] : FWD_BOX[get_byte(s, i)];
    end
    sub_bytes = t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = ((c + r) % 4) * 4 + r;
        if (inv) t[127-8*src -: 8] = get_byte(s, c*4 + r);
        else t[127-8*(c*4+r) -: 8] = get_byte(s, src);
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, u, v;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      if (inv) begin
        // inverse = forward mix of a column pre-conditioned by {05,00,04,00}
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        a0 = a0 ^ u;
        a1 = a1 ^ v;
        a2 = a2 ^ u;
        a3 = a3 ^ v;
      end
      u = a0 ^ a1 ^ a2 ^ a3;
      t[127-8*(4*c)   -: 8] = a0 ^ u ^ xtime(a0 ^ a1);
      t[127-8*(4*c+1) -: 8] = a1 ^ u ^ xtime(a1 ^ a2);
      t[127-8*(4*c+2) -: 8] = a2 ^ u ^ xtime(a2 ^ a3);
      t[127-8*(4*c+3) -: 8] = a3 ^ u ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {FWD_BOX[w3[23:16]] ^ rc, FWD_BOX[w3[15:8]], FWD_BOX[w3[7:0]], FWD_BOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// File: rtl/aes128_block_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// aes-128 encrypt/decrypt pipeline. a transaction (mode plus a 128-bit block) is taken at any
// rising edge with start_i high and busy_o low. the result sits on result_o with done_o high
// for exactly one cycle, after it has passed one input register, ten round stages and the
// output register. the receiver cannot stall; a done_o pulse must be taken when it shows. the
// round keys are expanded after reset and after each key write, one per cycle while no key
// write comes in, each by its own key schedule step, and then held in registers. busy_o is
// high while that runs: from the edge of a key write until the last round key of the last
// write of a run is in place. otherwise busy_o is low and a block can enter every cycle.
// keys may only be written while the pipeline is empty.
module aes128_block_cipher (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  output logic                  busy_o,
  input  wire aes128_pkg::aes_in_t  in_i,
  output logic                  done_o,
  output aes128_pkg::aes_out_t  result_o,
  input  wire                   cfg_we_i,
  input  wire  [0:0]            cfg_idx_i,
  input  wire  [63:0]           cfg_data_i
);
  import aes128_pkg::*;

  localparam int unsigned NumStg = NumRounds + 1;

  // key registers and the expanded schedule
  logic [127:0] key_q;
  logic [127:0] rk_q [NumRounds+1];
  logic [3:0]   exp_cnt_q;
  logic         exp_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      exp_run_q <= 1'b1;
      exp_cnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_KEY_HIGH: key_q[127:64] <= cfg_data_i;
        REG_KEY_LOW:  key_q[63:0]   <= cfg_data_i;
        default: ;
      endcase
      exp_run_q <= 1'b1;
      exp_cnt_q <= '0;
    end else if (exp_run_q) begin
      if (exp_cnt_q == 4'(NumRounds - 1)) exp_run_q <= 1'b0;
      exp_cnt_q <= exp_cnt_q + 4'd1;
    end
  end

  // one round key per cycle while no key write comes in: rk[1] from the key itself, rk[n+1] from rk[n]
  always_ff @(posedge clk_i) begin
    rk_q[0] <= key_q;
    if (exp_run_q && !cfg_we_i) begin
      if (exp_cnt_q == 4'd0) rk_q[1] <= next_key(key_q, RCON[0]);
      for (int r = 1; r < NumRounds; r++) begin
        if (exp_cnt_q == 4'(r)) rk_q[r+1] <= next_key(rk_q[r], RCON[r]);
      end
    end
  end

  // pipeline: stage 0 holds the input xor first key (last key when decrypting), stages 1..10 one round each
  logic [127:0] st_q   [NumStg];
  logic         mode_q [NumStg];
  logic         vld_q  [NumStg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStg; i++) vld_q[i] <= 1'b0;
      done_o <= 1'b0;
    end else begin
      vld_q[0] <= start_i && !busy_o;
      for (int i = 1; i < NumStg; i++) vld_q[i] <= vld_q[i-1];
      done_o <= vld_q[NumStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0]   <= {in_i.block_high, in_i.block_low}
                 ^ (in_i.mode ? rk_q[NumRounds] : rk_q[0]);
    mode_q[0] <= in_i.mode;
    for (int i = 1; i < NumStg; i++) begin
      mode_q[i] <= mode_q[i-1];
      if (!mode_q[i-1]) begin
        if (i == NumRounds)
          st_q[i] <= shift_rows(sub_bytes(st_q[i-1], 1'b0), 1'b0) ^ rk_q[i];
        else
          st_q[i] <= mix_columns(shift_rows(sub_bytes(st_q[i-1], 1'b0), 1'b0), 1'b0)
                     ^ rk_q[i];
      end else begin
        if (i == NumRounds)
          st_q[i] <= sub_bytes(shift_rows(st_q[i-1], 1'b1), 1'b1) ^ rk_q[0];
        else
          st_q[i] <= mix_columns(sub_bytes(shift_rows(st_q[i-1], 1'b1), 1'b1)
                     ^ rk_q[NumRounds-i], 1'b1);
      end
    end
    result_o <= st_q[NumStg-1];
  end

  // hold blocks off until the whole schedule matches the key
  assign busy_o = exp_run_q;

endmodule
`default_nettype wire
